FILE: rtl/gtm_pkg.sv
// ----------------------------------------------------------------------------
// gtm_pkg
// Shared widths, method codes, controller/datapath bundles and the
// saturating count add for the three-method gcd unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gtm_pkg;

  // operand width inside the datapath, port field widths are fixed
  localparam int WIDTH    = 32;
  localparam int FIELD_W  = 32;
  localparam int CNT_W    = 32;
  localparam int SUM_W    = ((WIDTH > CNT_W) ? WIDTH : CNT_W) + 1;
  localparam int METHOD_W = 2;

  // radix-4 divider: two quotient bits per cycle
  localparam int DIV_STEPS = (WIDTH + 1) / 2;
  localparam int DVD_W     = 2 * DIV_STEPS;
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [METHOD_W-1:0] {
    M_REM    = 2'd0,
    M_CONSEC = 2'd1,
    M_SUB    = 2'd2,
    M_SPARE  = 2'd3
  } method_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    div_euc;
    logic    div_scan;
    logic    euc_step;
    logic    scan_init;
    logic    scan_step;
    logic    fin;
    method_t method;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic y_zero;
    logic div_done;
    logic scan_stop;
    logic in_zero;
  } dp_stat_t;

  // add and clamp at the count maximum
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    return (s > (SUM_W+1)'(CNT_MAX)) ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gtm_div.sv
// ----------------------------------------------------------------------------
// gtm_div
// Iterative radix-4 restoring divider, DIV_STEPS steps for quotient and
// remainder; done pulses for one cycle when they are ready.
// ----------------------------------------------------------------------------
`default_nettype none

module gtm_div
  import gtm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  done,
  output logic [WIDTH-1:0]      quotient,
  output logic [WIDTH-1:0]      remainder
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [WIDTH-1:0]  rem;
  logic [DVD_W-1:0]  dvd;
  logic [WIDTH-1:0]  dsr;

  logic [WIDTH+1:0]  part;
  logic [WIDTH+1:0]  d1;
  logic [WIDTH+1:0]  d2;
  logic [WIDTH+1:0]  d3;
  logic [WIDTH+1:0]  part_next;
  logic [1:0]        qbits;

  // one radix-4 step: subtract the largest multiple that fits
  always_comb begin
    part = {rem, dvd[DVD_W-1 -: 2]};
    d1   = {2'b00, dsr};
    d2   = {1'b0, dsr, 1'b0};
    d3   = d1 + d2;
    if (part >= d3) begin
      part_next = part - d3;
      qbits     = 2'd3;
    end else if (part >= d2) begin
      part_next = part - d2;
      qbits     = 2'd2;
    end else if (part >= d1) begin
      part_next = part - d1;
      qbits     = 2'd1;
    end else begin
      part_next = part;
      qbits     = 2'd0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= DVD_W'(dividend);
      dsr <= divisor;
    end else if (busy) begin
      rem <= part_next[WIDTH-1:0];
      dvd <= {dvd[DVD_W-3:0], qbits};
    end
  end

  assign quotient  = dvd[WIDTH-1:0];
  assign remainder = rem;

  // a new division never starts on top of a running one
  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

FILE: rtl/gtm_datapath.sv
// ----------------------------------------------------------------------------
// gtm_datapath
// Operand, Euclid pair, divisor scan and count registers around the shared
// divider, plus the output word registers.
// ----------------------------------------------------------------------------
`default_nettype none

module gtm_datapath
  import gtm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            cmd,
  input  wire logic [FIELD_W-1:0] first_value,
  input  wire logic [FIELD_W-1:0] second_value,
  output dp_stat_t                stat,
  output logic [FIELD_W-1:0]      divisor_result,
  output logic [FIELD_W-1:0]      step_count
);

  logic [WIDTH-1:0] a_op;
  logic [WIDTH-1:0] op_a_in;
  logic [WIDTH-1:0] op_b_in;
  logic [WIDTH-1:0] mn;
  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] y;
  logic [WIDTH-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic             in_zero;
  logic             b_zero;

  logic             div_start;
  logic [WIDTH-1:0] div_dividend;
  logic [WIDTH-1:0] div_divisor;
  logic             div_done;
  logic [WIDTH-1:0] div_quo;
  logic [WIDTH-1:0] div_rem;

  logic [1:0]       inc;
  logic [WIDTH-1:0] res_next;
  logic [CNT_W-1:0] cnt_next;

  assign op_a_in = WIDTH'(first_value);
  assign op_b_in = WIDTH'(second_value);

  // shared divider, euclid pair or operand over scan divisor
  assign div_start    = cmd.div_euc | cmd.div_scan;
  assign div_dividend = cmd.div_scan ? a_op : x;
  assign div_divisor  = cmd.div_scan ? d : y;

  gtm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // divisor pair hits inside (gcd, min]
  always_comb begin
    inc = 2'((d > x) && (d <= mn)) +
          2'((div_quo != d) && (div_quo > x) && (div_quo <= mn));
  end

  // final word per method
  always_comb begin
    res_next = x;
    cnt_next = cnt;
    case (cmd.method)
      M_CONSEC: begin
        if (in_zero) begin
          res_next = '0;
          cnt_next = '0;
        end else begin
          cnt_next = sat_add(cnt, SUM_W'(mn - x) + SUM_W'(2));
        end
      end
      M_SUB: begin
        if (!b_zero) begin
          cnt_next = sat_add(cnt, SUM_W'(1'b1));
        end
      end
      default: begin
        cnt_next = cnt;
      end
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_op    <= op_a_in;
      x       <= op_a_in;
      y       <= op_b_in;
      mn      <= (op_a_in < op_b_in) ? op_a_in : op_b_in;
      cnt     <= '0;
      in_zero <= (op_a_in == '0) || (op_b_in == '0);
      b_zero  <= (op_b_in == '0);
    end
    if (cmd.euc_step) begin
      x <= y;
      y <= div_rem;
      if (cmd.method == M_SUB) begin
        cnt <= sat_add(cnt, SUM_W'(div_quo));
      end else begin
        cnt <= sat_add(cnt, SUM_W'(1'b1));
      end
    end
    if (cmd.scan_init) begin
      d   <= WIDTH'(1);
      cnt <= '0;
    end
    if (cmd.scan_step) begin
      if (div_rem == '0) begin
        cnt <= sat_add(cnt, SUM_W'(inc));
      end
      d <= d + 1'b1;
    end
    if (cmd.fin) begin
      divisor_result <= FIELD_W'(res_next);
      step_count     <= FIELD_W'(cnt_next);
    end
  end

  // status
  assign stat.y_zero    = (y == '0);
  assign stat.div_done  = div_done;
  assign stat.scan_stop = (d > div_quo);
  assign stat.in_zero   = in_zero;

  // the divider never sees a zero divisor
  assert property (@(posedge clk) disable iff (rst) cmd.div_euc |-> (y != '0))
    else $error("euclid division by zero");
  assert property (@(posedge clk) disable iff (rst) cmd.div_scan |-> (d != '0))
    else $error("scan division by zero");

endmodule

`default_nettype wire

FILE: rtl/gtm_ctrl.sv
// ----------------------------------------------------------------------------
// gtm_ctrl
// Sequencer for the Euclid loop and the divisor scan, method register,
// input ready and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module gtm_ctrl
  import gtm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wen,
  input  wire logic [METHOD_W-1:0] cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire dp_stat_t            stat,
  output dp_cmd_t                  cmd
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_EUC       = 6'b000010,
    S_EUC_WAIT  = 6'b000100,
    S_SCAN      = 6'b001000,
    S_SCAN_WAIT = 6'b010000,
    S_FIN       = 6'b100000
  } state_t;

  state_t  state;
  state_t  state_next;
  method_t method;
  logic    slot_free;

  // method register
  always_ff @(posedge clk) begin
    if (rst) begin
      method <= M_REM;
    end else if (cfg_wen) begin
      method <= method_t'(cfg_wdata);
    end
  end

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.method = method;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EUC;
        end
      end
      S_EUC: begin
        if (stat.y_zero) begin
          if (method == M_CONSEC && !stat.in_zero) begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          cmd.div_euc = 1'b1;
          state_next  = S_EUC_WAIT;
        end
      end
      S_EUC_WAIT: begin
        if (stat.div_done) begin
          cmd.euc_step = 1'b1;
          state_next   = S_EUC;
        end
      end
      S_SCAN: begin
        cmd.div_scan = 1'b1;
        state_next   = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        if (stat.div_done) begin
          if (stat.scan_stop) begin
            state_next = S_FIN;
          end else begin
            cmd.scan_step = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a finished word never overwrites one still waiting
  assert property (@(posedge clk) disable iff (rst) cmd.fin |-> slot_free)
    else $error("output word overwritten");

endmodule

`default_nettype wire

FILE: rtl/gcd_three_method_unit.sv
// ----------------------------------------------------------------------------
// gcd_three_method_unit
// Each divide of the Euclid loop or the divisor scan runs on the shared
//   divider; a word is valid once its Euclid divides are done, and method 1
//   with both operands nonzero adds the divisor scan before the word.
// Flow: one word in flight; the next word is accepted once the last one is
//   finished, while that result may still wait in the output register.
// Reset: synchronous rst clears the sequencer and output valid, method = 0.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_three_method_unit
  import gtm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wen,
  input  wire logic [METHOD_W-1:0] cfg_wdata,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [63:0]         s_axis_tdata,   // first_value, second_value
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [63:0]              m_axis_tdata    // divisor_result, step_count
);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [FIELD_W-1:0] divisor_result;
  logic [FIELD_W-1:0] step_count;

  // sequencer
  gtm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  gtm_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .first_value    (s_axis_tdata[FIELD_W-1:0]),
    .second_value   (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
    .stat           (stat),
    .divisor_result (divisor_result),
    .step_count     (step_count)
  );

  assign m_axis_tdata = {step_count, divisor_result};

endmodule

`default_nettype wire

FILE: tb/gcd_three_method_unit_test.sv
// ----------------------------------------------------------------------------
// gcd_three_method_unit_test
// Streams operand pairs into the gcd unit under each method setting and
// checks every result word against a predictor of gcd and operation count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gcd_three_method_unit_test;
  import gtm_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 50;
  localparam int PHASES         = 7;
  localparam int REPORT_LIMIT   = 10;

  // result word: divisor_result low, step_count high
  typedef struct packed {
    logic [31:0] step_count;
    logic [31:0] divisor_result;
  } gcd_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wen = 1'b0;
  logic [METHOD_W-1:0] cfg_wdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata = '0;   // first_value, second_value
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [63:0]         m_axis_tdata;        // divisor_result, step_count

  int unsigned idle_cycles = 0;
  int          burst_left = 1;

  // gcd and count predictor with a queue of expected result words
  class gcd_scoreboard;
    method_t   cur_method;
    gcd_word_t expected_q[$];
    int        mismatch_cnt;

    function new();
      cur_method   = M_REM;
      mismatch_cnt = 0;
    endfunction

    function void set_method(method_t m);
      cur_method = m;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function gcd_word_t predict_word(logic [31:0] a_in, logic [31:0] b_in);
      longint unsigned a, b, x, y, r, hi, lo, mn, g, d, e, steps;
      gcd_word_t w;
      a = a_in;
      b = b_in;
      g = 0;
      steps = 0;
      case (cur_method)
        M_CONSEC: begin
          // scan down from the smaller operand; zero operand gives zero
          if (a != 0 && b != 0) begin
            mn = (a < b) ? a : b;
            x = a;
            y = b;
            while (y != 0) begin
              r = x % y;
              x = y;
              y = r;
            end
            g = x;
            // every divisor of a above g and not above mn costs a second test
            for (d = 1; d <= a / d; d++) begin
              if (a % d == 0) begin
                e = a / d;
                if (d > g && d <= mn)
                  steps++;
                if (e != d && e > g && e <= mn)
                  steps++;
              end
            end
            steps += mn - g + 2;
          end
        end
        M_SUB: begin
          if (b == 0) begin
            g = a;
          end else if (a == 0) begin
            // one swap then one subtraction of zero
            g = b;
            steps = 1;
          end else begin
            hi = (a >= b) ? a : b;
            lo = (a >= b) ? b : a;
            while (lo != 0) begin
              steps += hi / lo;
              r = hi % lo;
              hi = lo;
              lo = r;
            end
            g = hi;
            steps += 1;
          end
        end
        default: begin
          // remainder euclid, spare code too
          x = a;
          y = b;
          while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
            steps++;
          end
          g = x;
        end
      endcase
      w.divisor_result = g[31:0];
      w.step_count     = (steps > 64'hFFFF_FFFF) ? '1 : steps[31:0];
      return w;
    endfunction

    function void note_operands(logic [31:0] a, logic [31:0] b);
      expected_q.push_back(predict_word(a, b));
    endfunction

    function void check_word(logic [63:0] data);
      gcd_word_t got, want;
      got = data;
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT)
          $display("unexpected word: gcd %0d steps %0d", got.divisor_result,
                   got.step_count);
        return;
      end
      want = expected_q.pop_front();
      if (got.divisor_result !== want.divisor_result ||
          got.step_count !== want.step_count) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT)
          $display("mismatch: expected gcd %0d steps %0d, got gcd %0d steps %0d",
                   want.divisor_result, want.step_count,
                   got.divisor_result, got.step_count);
      end
    endfunction
  endclass

  gcd_scoreboard sb = new();

  gcd_three_method_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stall pattern: windows of always ready, random, sparse, slow toggle
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(50, 400);
      for (int i = 0; i < span; i++) begin
        @(posedge clk);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          2: m_axis_tready <= ($urandom_range(0, 7) == 0);
          default: m_axis_tready <= ((i / 8) % 2 == 0);
        endcase
      end
    end
  end

  // send one operand pair, bursts with random gaps in between
  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_operands(a, b);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 120)
                                        : $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // wait for every result, then write the method register
  task automatic write_method(method_t m);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sb.set_method(m);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $urandom_range(0, 300);
      6: begin
        case ($urandom_range(0, 3))
          0:       return 32'd0;
          1:       return 32'd1;
          2:       return 32'hFFFF_FFFF;
          default: return 32'hFFFF_FFFE;
        endcase
      end
      7:       return 32'h1 << $urandom_range(0, 31);
      8:       return 32'hFFFF_FFFF >> $urandom_range(0, 31);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // pairs for the euclid methods: independent, shared factor, fibonacci, equal
  task automatic send_euclid_pair();
    logic [31:0] a, b, g, t;
    int n;
    case ($urandom_range(0, 9))
      6, 7: begin
        g = $urandom_range(1, 65535);
        a = g * $urandom_range(0, 65535);
        b = g * $urandom_range(0, 65535);
      end
      8: begin
        // consecutive fibonacci numbers give the longest euclid runs
        n = $urandom_range(2, 46);
        a = 0;
        b = 1;
        repeat (n) begin
          t = a + b;
          a = b;
          b = t;
        end
      end
      9: begin
        a = rand_operand();
        b = a;
      end
      default: begin
        a = rand_operand();
        b = rand_operand();
      end
    endcase
    if ($urandom_range(0, 1))
      send_pair(a, b);
    else
      send_pair(b, a);
  endtask

  // pairs for the consecutive scan: first operand kept small, scan time grows
  // with its square root
  task automatic send_scan_pair();
    logic [31:0] a, b, g;
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)
      a = 0;
    else if (r < 13)
      a = $urandom_range(1024, 65535);
    else
      a = $urandom_range(1, 1023);
    r = $urandom_range(0, 99);
    if (r < 5) begin
      b = 0;
    end else if (r < 35) begin
      b = $urandom;
    end else if (r < 65) begin
      b = $urandom_range(1, 2047);
    end else if (r < 85) begin
      g = $urandom_range(1, 64);
      a = g * $urandom_range(0, 1023 / g);
      b = g * $urandom_range(0, 100000);
    end else begin
      b = a * $urandom_range(1, 1000);
    end
    send_pair(a, b);
  endtask

  task automatic send_directed(method_t m);
    case (m)
      M_REM: begin
        send_pair(32'd0, 32'd0);
        send_pair(32'd5, 32'd0);
        send_pair(32'd0, 32'd7);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'd1);
        send_pair(32'd1, 32'hFFFF_FFFF);
        send_pair(32'd2971215073, 32'd1836311903);
        send_pair(32'h8000_0000, 32'h4000_0000);
      end
      M_SUB: begin
        send_pair(32'd0, 32'd0);
        send_pair(32'd9, 32'd0);
        send_pair(32'd0, 32'd9);
        // count runs past the 32-bit maximum and clamps
        send_pair(32'hFFFF_FFFF, 32'd1);
        send_pair(32'd1, 32'hFFFF_FFFF);
        send_pair(32'd12, 32'd18);
        send_pair(32'd1836311903, 32'd2971215073);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      end
      M_CONSEC: begin
        send_pair(32'd0, 32'd5);
        send_pair(32'd5, 32'd0);
        send_pair(32'd0, 32'd0);
        send_pair(32'hFFFF_FFFF, 32'd0);
        send_pair(32'd0, 32'hFFFF_FFFF);
        send_pair(32'd1, 32'd1);
        send_pair(32'd12, 32'd18);
        send_pair(32'd97, 32'd1000003);
        send_pair(32'd720720, 32'hFFFF_FFFF);
      end
      default: begin
        // spare code runs as remainder euclid
        send_pair(32'd48, 32'd18);
        send_pair(32'd0, 32'd3);
      end
    endcase
  endtask

  // main sequence
  initial begin
    method_t plan_method[PHASES];
    int      plan_items[PHASES];
    bit      directed_done[4];
    plan_method = '{M_REM, M_SUB, M_CONSEC, M_SPARE, M_REM, M_CONSEC, M_SUB};
    plan_items  = '{200, 200, 150, 100, 100, 100, 200};
    directed_done = '{default: 1'b0};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      // first phase runs on the reset value of the method register
      if (p != 0)
        write_method(plan_method[p]);
      if (!directed_done[plan_method[p]]) begin
        send_directed(plan_method[p]);
        directed_done[plan_method[p]] = 1'b1;
      end
      for (int i = 0; i < plan_items[p]; i++) begin
        if (plan_method[p] == M_CONSEC)
          send_scan_pair();
        else
          send_euclid_pair();
      end
    end

    // drain
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatch_cnt == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
